// ===== rtl/mvts_pkg.sv =====
// Shared constants, types and the sine quarter-wave table for the tone synthesizer.
// No dependencies; imported by the top level and by its port checker.
`default_nettype none
package mvts_pkg;

  localparam int MAX_EVENTS     = 128;
  localparam int FRAMES_PER_SEC = 48000;
  localparam int TABLE_BITS     = 10;

  localparam int IDX_W   = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int CNT_W   = $clog2(MAX_EVENTS + 1);
  localparam int QBITS   = TABLE_BITS - 2;
  localparam int QUARTER = 1 << QBITS;
  localparam int QW      = QBITS + 1;

  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 48;
  localparam int SUM_W      = 17 + CNT_W + 1;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_CLEAR  = 2'd1,
    OP_RENDER = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  localparam logic [2:0] VT_SAW    = 3'd2;
  localparam logic [2:0] VT_SQUARE = 3'd3;
  localparam logic [2:0] VT_KICK   = 3'd4;
  localparam logic [2:0] VT_SNARE  = 3'd5;
  localparam logic [2:0] VT_HAT    = 3'd6;
  localparam logic [2:0] VT_CHIRP  = 3'd7;

  localparam int EXP_SCALE  = 94548;
  localparam int EXP_K_KICK = 8;
  localparam int EXP_K_SNR  = 12;
  localparam int EXP_K_HAT  = 25;

  // voice_type sits in the lowest bits, matching the input tdata layout
  typedef struct packed {
    logic [15:0] gain;
    logic [23:0] end_step;
    logic [23:0] start_step;
    logic [23:0] length_frames;
    logic [23:0] start_frame;
    logic [2:0]  voice_type;
  } evt_t;

  typedef logic [14:0] sin_tab_t [0:QUARTER];

  // Quarter-wave magnitudes from the odd degree-9 polynomial, Q15 rounded.
  function automatic sin_tab_t build_sin_tab();
    sin_tab_t tab;
    longint unsigned x, x2, t, y, v;
    for (int r = 0; r <= QUARTER; r++) begin
      x  = longint'(r) << (16 - QBITS);
      x2 = (x * x) >> 16;
      t  = 64'd43068;
      t  = 64'd1256749 - ((x2 * t) >> 16);
      t  = 64'd21392326 - ((x2 * t) >> 16);
      t  = 64'd173399667 - ((x2 * t) >> 16);
      t  = 64'd421657428 - ((x2 * t) >> 16);
      y  = (x * t) >> 16;
      v  = (y + 64'd4096) >> 13;
      if (v > 64'd32767) v = 64'd32767;
      tab[r] = 15'(v);
    end
    return tab;
  endfunction

  localparam sin_tab_t SIN_TAB = build_sin_tab();

  function automatic logic signed [15:0] sine_of(input logic [23:0] ph);
    logic [TABLE_BITS-1:0] idx;
    logic [1:0]            quad;
    logic [QW-1:0]         rr;
    logic signed [15:0]    sv;
    idx  = ph[23 -: TABLE_BITS];
    quad = idx[TABLE_BITS-1 -: 2];
    rr   = quad[0] ? (QW'(QUARTER) - {1'b0, idx[QBITS-1:0]}) : {1'b0, idx[QBITS-1:0]};
    sv   = $signed({1'b0, SIN_TAB[rr]});
    return quad[1] ? -sv : sv;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/multi_voice_tone_synth.sv =====
// Multi-voice tone synthesizer: event table, per-voice phase memory and a
// sequencer around one shared multiplier. Depends on mvts_pkg.
//
// Load transactions store a note event in the next free table slot (or report
// load_refused when all MAX_EVENTS slots are used); clear empties the table and
// resets the frame counter; render mixes every event active at the current
// frame into one clipped 16-bit sample and advances the frame counter. Each
// transaction gives exactly one result. A render checks each stored event in
// turn and skips those not active; an active event takes a 16-bit
// bit-serial divide for the envelope progress, then a voice-dependent walk
// through the single multiplier, where the exponential envelopes (kick and
// noise voices) dominate with a six-term series.
// The table and phase memories each have one read port, so events are
// visited strictly one after another. The input is taken again as soon as the
// sequencer is idle; a finished result waits in the output register.
`default_nettype none
module multi_voice_tone_synth import mvts_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  // voice_type[2:0], start_frame[26:3], length_frames[50:27], start_step[74:51],
  // end_step[98:75], gain[114:99], zero fill above
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // op[1:0]
  input  logic [1:0]            s_axis_tuser_i,
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  // pcm[15:0], frame_number[39:16], load_refused[40], zero fill above
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  typedef enum logic [5:0] {
    ST_IDLE, ST_RD, ST_CHK, ST_DIV, ST_SETUP, ST_STEP2,
    ST_SIN_A, ST_SIN_B, ST_SAW_A, ST_SAW_B, ST_SQ_A, ST_SQ_B, ST_SQ_C,
    ST_NZ_A, ST_NZ_B, ST_NZ_C, ST_NZ_D,
    ST_FM_A, ST_FM_B, ST_FM_C, ST_FM_D, ST_FM_E, ST_FM_F,
    ST_EXP_A, ST_EXP_B, ST_EXP_C, ST_EXP_D, ST_EXP_E, ST_EXP_F, ST_EXP_G,
    ST_EXP_H, ST_EXP_I,
    ST_MIX_A, ST_MIX_B, ST_MIX_C, ST_FIN
  } state_e;

  state_e state_q;

  evt_t        evt_mem [MAX_EVENTS];
  logic [23:0] ph_mem  [MAX_EVENTS];
  evt_t        ev_q;
  logic [23:0] ph_rd_q;

  logic [CNT_W-1:0] count_q, e_q;
  logic [23:0]      frame_q;
  logic [15:0]      lfsr_q;
  op_e              op_q;
  logic             ref_pend_q;

  logic                    out_valid_q, refused_q;
  logic [15:0]             pcm_q;
  logic [23:0]             fnum_q;

  logic [23:0]             s_q, rem_q, len_q, ph_q, sin_arg_q;
  logic [15:0]             p_q, frac_q, z_q, x_q;
  logic [3:0]              div_cnt_q;
  logic [16:0]             lin_q, env_q, t_q;
  logic signed [15:0]      w_q;
  logic                    neg_q, sa_q;
  logic [24:0]             mag_q;
  logic [21:0]             expk_q;
  logic [5:0]              n_q;
  logic [2:0]              k_q;
  logic signed [SUM_W-1:0] sum_q;
  logic [63:0]             prod_q;

  // handshake and op decode
  logic accept, evt_we, table_full;
  op_e  op_in;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept     = s_axis_tvalid_i && s_axis_tready_o;
  assign op_in      = op_e'(s_axis_tuser_i);
  assign table_full = (count_q >= CNT_W'(MAX_EVENTS));
  assign evt_we     = accept && (op_in == OP_LOAD) && !table_full;

  // event activity check
  logic [23:0] len_eff, sdiff;
  logic        active, last_evt;
  assign len_eff  = (ev_q.length_frames == 24'd0) ? 24'(FRAMES_PER_SEC) : ev_q.length_frames;
  assign sdiff    = frame_q - ev_q.start_frame;
  assign active   = (frame_q >= ev_q.start_frame) && (sdiff < len_eff);
  assign last_evt = ((e_q + 1'b1) == count_q);

  // phase glide
  logic        up;
  logic [23:0] dstep, step, nph;
  assign up    = (ev_q.end_step >= ev_q.start_step);
  assign dstep = up ? (ev_q.end_step - ev_q.start_step) : (ev_q.start_step - ev_q.end_step);
  assign step  = up ? (ev_q.start_step + prod_q[39:16]) : (ev_q.start_step - prod_q[39:16]);
  assign nph   = ph_q + step;

  logic signed [15:0] sin_val;
  assign sin_val = sine_of(sin_arg_q);

  logic [15:0] lfsr_n;
  assign lfsr_n = {1'b0, lfsr_q[15:1]} ^ (lfsr_q[0] ? LFSR_TAPS : 16'd0);

  // sawtooth from the phase taken as a signed fraction
  logic [23:0] saw_mag;
  logic [37:0] saw_scaled;
  logic [14:0] saw_w;
  assign saw_mag    = ph_q[23] ? (24'd0 - ph_q) : ph_q;
  assign saw_scaled = {saw_mag, 14'd0} + {saw_mag, 14'd0} - {14'd0, saw_mag};
  assign saw_w      = saw_scaled[37:23];

  // noise sample: remainder by 2000, offset, scale to full range
  logic [16:0]        nz_q2k;
  logic [15:0]        nz_rem;
  logic signed [11:0] nz_d;
  logic [9:0]         nz_mag;
  assign nz_q2k = {11'd0, prod_q[32:27]} * 17'd2000;
  assign nz_rem = lfsr_q - nz_q2k[15:0];
  assign nz_d   = $signed({1'b0, nz_rem[10:0]}) - 12'sd1000;
  assign nz_mag = nz_d[11] ? 10'(-nz_d) : nz_d[9:0];

  logic [26:0] fm_arg;
  logic [14:0] sin_abs;
  logic [21:0] fm_off;
  assign fm_arg  = {p_q, 11'd0} + {1'b0, p_q, 10'd0};
  assign sin_abs = sin_val[15] ? 15'(-sin_val) : sin_val[14:0];
  assign fm_off  = prod_q[49:28];

  // series divisor k as reciprocal multiply and shift
  logic [31:0] recip;
  logic [4:0]  rsh;
  logic [15:0] divq;
  always_comb begin
    case (k_q)
      3'd2:    begin recip = 32'd1;     rsh = 5'd1;  end
      3'd3:    begin recip = 32'd43691; rsh = 5'd17; end
      3'd4:    begin recip = 32'd1;     rsh = 5'd2;  end
      3'd5:    begin recip = 32'd52429; rsh = 5'd18; end
      3'd6:    begin recip = 32'd43691; rsh = 5'd18; end
      default: begin recip = 32'd1;     rsh = 5'd0;  end
    endcase
  end
  assign divq = 16'(prod_q[31:0] >> rsh);

  logic [15:0] wmag;
  assign wmag = w_q[15] ? 16'(-w_q) : w_q;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  always_comb begin
    case (state_q)
      ST_SETUP: begin mul_a = {8'd0, dstep};      mul_b = {16'd0, p_q};    end
      ST_SAW_A: begin mul_a = {15'd0, lin_q};     mul_b = 32'd39322;       end
      ST_SQ_A:  begin mul_a = {8'd0, ph_q};       mul_b = 32'd21474837;    end
      ST_NZ_A:  begin mul_a = {16'd0, lfsr_n};    mul_b = 32'd67109;       end
      ST_NZ_C:  begin mul_a = {7'd0, mag_q};      mul_b = 32'd34359739;    end
      ST_FM_C:  begin mul_a = {7'd0, mag_q};      mul_b = 32'd26843546;    end
      ST_EXP_A: begin mul_a = {16'd0, p_q};       mul_b = {10'd0, expk_q}; end
      ST_EXP_C: begin mul_a = {16'd0, frac_q};    mul_b = 32'd45426;       end
      ST_EXP_E: begin mul_a = {16'd0, z_q};       mul_b = {15'd0, t_q};    end
      ST_EXP_G: begin mul_a = {16'd0, x_q};       mul_b = recip;           end
      ST_MIX_A: begin mul_a = {16'd0, wmag};      mul_b = {16'd0, ev_q.gain}; end
      ST_MIX_B: begin mul_a = prod_q[31:0];       mul_b = {15'd0, env_q};  end
      default:  begin mul_a = 32'd0;              mul_b = 32'd0;           end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  localparam logic signed [SUM_W-1:0] PCM_MAX = SUM_W'(32767);
  localparam logic signed [SUM_W-1:0] PCM_MIN = -PCM_MAX;
  logic [15:0] pcm_clip;
  always_comb begin
    if (sum_q > PCM_MAX)      pcm_clip = PCM_MAX[15:0];
    else if (sum_q < PCM_MIN) pcm_clip = PCM_MIN[15:0];
    else                      pcm_clip = sum_q[15:0];
  end

  // memories
  logic             ph_we;
  logic [IDX_W-1:0] ph_wa;
  logic [23:0]      ph_wd;
  assign ph_we = evt_we || (state_q == ST_STEP2);
  assign ph_wa = evt_we ? count_q[IDX_W-1:0] : e_q[IDX_W-1:0];
  assign ph_wd = evt_we ? 24'd0 : nph;

  always_ff @(posedge clk_i) begin
    if (evt_we) evt_mem[count_q[IDX_W-1:0]] <= evt_t'(s_axis_tdata_i[$bits(evt_t)-1:0]);
    ev_q <= evt_mem[e_q[IDX_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (ph_we) ph_mem[ph_wa] <= ph_wd;
    ph_rd_q <= ph_mem[e_q[IDX_W-1:0]];
  end

  // sequencer and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      e_q         <= '0;
      frame_q     <= '0;
      lfsr_q      <= LFSR_SEED;
      op_q        <= OP_NONE;
      ref_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
      refused_q   <= 1'b0;
      pcm_q       <= '0;
      fnum_q      <= '0;
    end else begin
      if (out_valid_q && m_axis_tready_i && state_q != ST_FIN) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            op_q       <= op_in;
            ref_pend_q <= (op_in == OP_LOAD) && table_full;
            state_q    <= ((op_in == OP_RENDER) && (count_q != '0)) ? ST_RD : ST_FIN;
            case (op_in)
              OP_LOAD: begin
                if (!table_full) count_q <= count_q + 1'b1;
              end
              OP_CLEAR: begin
                count_q <= '0;
                frame_q <= '0;
              end
              OP_RENDER: begin
                e_q <= '0;
              end
              default: ;
            endcase
          end
        end
        ST_RD: state_q <= ST_CHK;
        ST_CHK: begin
          if (active) begin
            state_q <= ST_DIV;
          end else begin
            e_q     <= e_q + 1'b1;
            state_q <= last_evt ? ST_FIN : ST_RD;
          end
        end
        ST_DIV:   if (div_cnt_q == 4'd15) state_q <= ST_SETUP;
        ST_SETUP: state_q <= ST_STEP2;
        ST_STEP2: begin
          case (ev_q.voice_type)
            VT_SAW:    state_q <= ST_SAW_A;
            VT_SQUARE: state_q <= ST_SQ_A;
            VT_SNARE:  state_q <= ST_NZ_A;
            VT_HAT:    state_q <= ST_NZ_A;
            VT_CHIRP:  state_q <= ST_FM_A;
            default:   state_q <= ST_SIN_A;
          endcase
        end
        ST_SIN_A: state_q <= ST_SIN_B;
        ST_SIN_B: state_q <= (ev_q.voice_type == VT_KICK) ? ST_EXP_A : ST_MIX_A;
        ST_SAW_A: state_q <= ST_SAW_B;
        ST_SAW_B: state_q <= ST_MIX_A;
        ST_SQ_A:  state_q <= ST_SQ_B;
        ST_SQ_B:  state_q <= ST_SQ_C;
        ST_SQ_C:  state_q <= ST_MIX_A;
        ST_NZ_A: begin
          lfsr_q  <= lfsr_n;
          state_q <= ST_NZ_B;
        end
        ST_NZ_B:  state_q <= ST_NZ_C;
        ST_NZ_C:  state_q <= ST_NZ_D;
        ST_NZ_D:  state_q <= ST_EXP_A;
        ST_FM_A:  state_q <= ST_FM_B;
        ST_FM_B:  state_q <= ST_FM_C;
        ST_FM_C:  state_q <= ST_FM_D;
        ST_FM_D:  state_q <= ST_FM_E;
        ST_FM_E:  state_q <= ST_FM_F;
        ST_FM_F:  state_q <= ST_MIX_A;
        ST_EXP_A: state_q <= ST_EXP_B;
        ST_EXP_B: state_q <= ST_EXP_C;
        ST_EXP_C: state_q <= ST_EXP_D;
        ST_EXP_D: state_q <= ST_EXP_E;
        ST_EXP_E: state_q <= ST_EXP_F;
        ST_EXP_F: state_q <= ST_EXP_G;
        ST_EXP_G: state_q <= ST_EXP_H;
        ST_EXP_H: state_q <= (k_q == 3'd1) ? ST_EXP_I : ST_EXP_E;
        ST_EXP_I: state_q <= ST_MIX_A;
        ST_MIX_A: state_q <= ST_MIX_B;
        ST_MIX_B: state_q <= ST_MIX_C;
        ST_MIX_C: begin
          e_q     <= e_q + 1'b1;
          state_q <= last_evt ? ST_FIN : ST_RD;
        end
        ST_FIN: begin
          // hold until the output register is free
          if (!out_valid_q || m_axis_tready_i) begin
            out_valid_q <= 1'b1;
            refused_q   <= ref_pend_q;
            if (op_q == OP_RENDER) begin
              pcm_q   <= pcm_clip;
              fnum_q  <= frame_q;
              frame_q <= frame_q + 1'b1;
            end else begin
              pcm_q  <= '0;
              fnum_q <= '0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  logic [24:0] rem2;
  assign rem2 = {rem_q, 1'b0};

  always_ff @(posedge clk_i) begin
    prod_q <= mul_p;
    case (state_q)
      ST_IDLE: if (accept && op_in == OP_RENDER) sum_q <= '0;
      ST_CHK: begin
        s_q       <= sdiff;
        rem_q     <= sdiff;
        len_q     <= len_eff;
        p_q       <= '0;
        div_cnt_q <= '0;
      end
      ST_DIV: begin
        if (rem2 >= {1'b0, len_q}) begin
          rem_q <= 24'(rem2 - {1'b0, len_q});
          p_q   <= {p_q[14:0], 1'b1};
        end else begin
          rem_q <= rem2[23:0];
          p_q   <= {p_q[14:0], 1'b0};
        end
        div_cnt_q <= div_cnt_q + 1'b1;
      end
      ST_SETUP: begin
        // force the phase to zero at the event onset
        ph_q  <= (s_q == 24'd0) ? 24'd0 : ph_rd_q;
        lin_q <= 17'h10000 - {1'b0, p_q};
      end
      ST_STEP2: begin
        case (ev_q.voice_type)
          VT_KICK:  expk_q <= 22'(EXP_K_KICK * EXP_SCALE);
          VT_SNARE: expk_q <= 22'(EXP_K_SNR * EXP_SCALE);
          default:  expk_q <= 22'(EXP_K_HAT * EXP_SCALE);
        endcase
      end
      ST_SIN_A: sin_arg_q <= ph_q;
      ST_SIN_B: begin
        w_q   <= sin_val;
        env_q <= lin_q;
      end
      ST_SAW_A: begin
        w_q       <= ph_q[23] ? -$signed({1'b0, saw_w}) : $signed({1'b0, saw_w});
        sin_arg_q <= {p_q[13:0], 10'd0};
      end
      ST_SAW_B: env_q <= (sin_val <= 16'sd0) ? prod_q[32:16] : lin_q;
      ST_SQ_A:  sin_arg_q <= ph_q;
      ST_SQ_B: begin
        sa_q      <= !sin_val[15];
        sin_arg_q <= ph_q + {6'd0, prod_q[48:31]};
      end
      ST_SQ_C: begin
        if (sa_q && !sin_val[15])      w_q <= 16'sd32767;
        else if (!sa_q && sin_val[15]) w_q <= -16'sd32767;
        else                           w_q <= 16'sd0;
        env_q <= lin_q;
      end
      ST_NZ_B: begin
        neg_q <= nz_d[11];
        mag_q <= {nz_mag, 15'd0} - {15'd0, nz_mag};
      end
      ST_NZ_D: w_q <= neg_q ? 16'(-prod_q[50:35]) : prod_q[50:35];
      ST_FM_A: sin_arg_q <= fm_arg[23:0];
      ST_FM_B: begin
        neg_q <= sin_val[15];
        mag_q <= {sin_abs, 10'd0};
      end
      ST_FM_D: sin_arg_q <= neg_q ? (ph_q - {2'd0, fm_off}) : (ph_q + {2'd0, fm_off});
      ST_FM_E: begin
        w_q       <= sin_val;
        sin_arg_q <= {1'b0, p_q, 7'd0};
      end
      ST_FM_F: begin
        if (!sin_val[15] && sin_val != 16'sd0) env_q <= {1'b0, sin_val[14:0], 1'b0};
        else                                   env_q <= '0;
      end
      ST_EXP_B: begin
        n_q    <= prod_q[37:32];
        frac_q <= prod_q[31:16];
      end
      ST_EXP_D: begin
        z_q <= prod_q[31:16];
        t_q <= 17'h10000;
        k_q <= 3'd6;
      end
      ST_EXP_F: x_q <= prod_q[31:16];
      ST_EXP_H: begin
        t_q <= 17'h10000 - {1'b0, divq};
        k_q <= k_q - 1'b1;
      end
      ST_EXP_I: env_q <= (n_q >= 6'd17) ? 17'd0 : (t_q >> n_q);
      ST_MIX_C: begin
        // truncate the magnitude, then apply the sign
        if (w_q[15]) sum_q <= sum_q - $signed({{(SUM_W-17){1'b0}}, prod_q[46:30]});
        else         sum_q <= sum_q + $signed({{(SUM_W-17){1'b0}}, prod_q[46:30]});
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W-41){1'b0}}, refused_q, fnum_q, pcm_q};

endmodule
`default_nettype wire

// ===== rtl/mvts_checker.sv =====
// Port-level checks for multi_voice_tone_synth, bound to the top level.
// Depends on mvts_pkg for the stream widths.
`default_nettype none
module mvts_checker import mvts_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  s_axis_tvalid_i,
  input wire logic                  s_axis_tready_o,
  input wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input wire logic [1:0]            s_axis_tuser_i,
  input wire logic                  m_axis_tvalid_o,
  input wire logic                  m_axis_tready_i,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata_o
);

  // a stalled result transaction holds its data
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // the input is closed in the cycle after every accepted transaction
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input ready right after an accepted transaction");

  // clipping is symmetric: the most negative code never appears
  a_pcm_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[15:0] != 16'h8000)
    else $error("pcm outside the clipped range");

  // a refused load carries no sample and no frame number
  a_refused_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[40] |-> m_axis_tdata_o[39:0] == 40'd0)
    else $error("refused load with nonzero payload");

endmodule

bind multi_voice_tone_synth mvts_checker u_mvts_checker (.*);
`default_nettype wire
